// File: hw/rtl/hrsp_pkg.sv
// Shared types, constants and character decode functions for the hex record parser.
package hrsp_pkg;

  // Build-time defaults for the top level parameters.
  localparam int unsigned MaxDataBytesDefault = 255;
  localparam int unsigned OutDepthDefault     = 4;

  // Configuration port geometry and register indexes.
  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned CfgIndexW = 1;
  localparam logic [CfgIndexW-1:0] CFG_FIRST_LINE = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_FINAL_LINE = 1'b1;

  // Character codes.
  localparam logic [7:0] CharNewline = 8'd10;
  localparam logic [7:0] Char0       = 8'h30;
  localparam logic [7:0] Char9       = 8'h39;
  localparam logic [7:0] CharLowA    = 8'h61;
  localparam logic [7:0] CharLowF    = 8'h66;
  localparam logic [7:0] CharUpA     = 8'h41;
  localparam logic [7:0] CharUpF     = 8'h46;
  localparam logic [7:0] CharUpZ     = 8'h5A;

  // Value reported for a gap run and the saturation point of the line position.
  localparam logic [7:0] FillByte = 8'hFF;
  localparam logic [9:0] PosMax   = 10'd1023;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_GAP    = 2'd1,
    KIND_RECORD = 2'd2,
    KIND_DONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } char_beat_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  byte_value;
    logic [15:0] gap_length;
    logic [7:0]  rec_type;
    logic [7:0]  rec_length;
    logic [7:0]  checksum;
    logic        last;
  } result_t;

  // Hex digit value; any other code keeps its own 8-bit value.
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    if (c >= Char0 && c <= Char9) begin
      v = c - Char0;
    end else if (c >= CharLowA && c <= CharLowF) begin
      v = c - CharLowA + 8'd10;
    end else if (c >= CharUpA && c <= CharUpF) begin
      v = c - CharUpA + 8'd10;
    end
    return v;
  endfunction

  // Upper case letters map to lower case; other codes pass unchanged.
  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CharUpA && c <= CharUpZ) begin
      r = c + (CharLowA - CharUpA);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/hrsp_stream_if.sv
// Valid/ready stream interface carrying one payload per beat.
interface hrsp_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/hrsp_parse.sv
// Line parser: field registers, configuration registers and per-beat result generation.
module hrsp_parse #(
  parameter int unsigned MAX_DATA_BYTES = hrsp_pkg::MaxDataBytesDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [hrsp_pkg::CfgIndexW-1:0]      wr_index,
  input  logic [hrsp_pkg::CfgWidth-1:0]       wr_data,
  input  logic                                accept,
  input  hrsp_pkg::char_beat_t                beat,
  output hrsp_pkg::result_t                   res0,
  output hrsp_pkg::result_t                   res1,
  output logic [1:0]                          res_count
);
  import hrsp_pkg::*;

  // Fixed character positions within a line.
  localparam logic [9:0] PosLenHi   = 10'd1;
  localparam logic [9:0] PosLenLo   = 10'd2;
  localparam logic [9:0] PosAddr3   = 10'd3;
  localparam logic [9:0] PosAddr2   = 10'd4;
  localparam logic [9:0] PosAddr1   = 10'd5;
  localparam logic [9:0] PosAddr0   = 10'd6;
  localparam logic [9:0] PosTypeHi  = 10'd7;
  localparam logic [9:0] PosTypeLo  = 10'd8;
  localparam logic [9:0] PosData    = 10'd9;
  localparam logic [7:0] MaxBytes   = 8'(MAX_DATA_BYTES);

  // Configuration and stream state.
  logic [15:0] first_line;
  logic [15:0] final_line;
  logic [9:0]  char_position;
  logic [15:0] line_count;
  logic [7:0]  field_length;
  logic [15:0] field_address;
  logic [7:0]  field_type;
  logic [7:0]  field_checksum;
  logic [7:0]  high_nibble;
  logic [15:0] data_address;
  logic        gap_pending;
  logic [15:0] gap_start;

  logic [9:0]  char_position_next;
  logic [15:0] line_count_next;
  logic [7:0]  field_length_next;
  logic [15:0] field_address_next;
  logic [7:0]  field_type_next;
  logic [7:0]  field_checksum_next;
  logic [7:0]  high_nibble_next;
  logic [15:0] data_address_next;
  logic        gap_pending_next;
  logic [15:0] gap_start_next;

  logic        is_eot;
  logic        is_newline;
  logic        finish_active;
  logic        in_range;
  logic [7:0]  v;
  logic [7:0]  vd;
  logic [7:0]  data_len;
  logic [9:0]  dend;
  logic [15:0] gap_cmp_addr;
  logic        gap_fire;
  logic        gap_at_finish;
  logic        gap_at_addr;
  logic        rec_fire;
  logic        data_fire;
  logic [7:0]  data_byte;
  result_t     gap_res;
  result_t     rec_res;
  result_t     done_res;
  result_t     data_res;

  assign is_eot        = beat.end_of_text;
  assign is_newline    = !is_eot && (beat.char_code == CharNewline);
  assign finish_active = is_newline || (is_eot && (char_position != 10'd0));
  assign in_range      = (line_count >= first_line) && (line_count <= final_line);
  assign v             = hex_value(beat.char_code);
  assign vd            = hex_value(fold_lower(beat.char_code));
  assign data_len      = (field_length < MaxBytes) ? field_length : MaxBytes;
  assign dend          = PosData + {1'b0, data_len, 1'b0};

  // Field capture for an ordinary character.
  always_comb begin
    field_length_next   = field_length;
    field_address_next  = field_address;
    field_type_next     = field_type;
    field_checksum_next = field_checksum;
    high_nibble_next    = high_nibble;
    data_address_next   = data_address;
    data_fire           = 1'b0;
    data_byte           = {high_nibble[3:0], 4'b0000} | vd;
    case (char_position)
      PosLenHi:  field_length_next = {v[3:0], 4'b0000};
      PosLenLo:  field_length_next = field_length | v;
      PosAddr3:  field_address_next[15:8] = {v[3:0], 4'b0000};
      PosAddr2:  field_address_next[15:8] = field_address[15:8] | v;
      PosAddr1:  field_address_next[7:0] = {v[3:0], 4'b0000};
      PosAddr0:  field_address_next[7:0] = field_address[7:0] | v;
      PosTypeHi: field_type_next = {v[3:0], 4'b0000};
      PosTypeLo: begin
        field_type_next   = field_type | v;
        data_address_next = field_address;
      end
      default: begin
        if (char_position >= PosData && char_position < dend) begin
          // Data digits alternate high and low nibble, starting odd.
          if (char_position[0]) begin
            high_nibble_next = vd;
          end else begin
            data_fire         = in_range && (field_type == 8'd0);
            data_address_next = data_address + 16'd1;
          end
        end else if (char_position == dend) begin
          field_checksum_next = {v[3:0], 4'b0000};
        end else if (char_position == dend + 10'd1) begin
          field_checksum_next = field_checksum | v;
        end
      end
    endcase
  end

  // Gap check runs after the last address digit or when a short line ends.
  assign gap_cmp_addr  = finish_active ? field_address : field_address_next;
  assign gap_fire      = gap_pending && (gap_cmp_addr > gap_start);
  assign gap_at_finish = finish_active && (char_position < PosTypeHi) && gap_fire;
  assign gap_at_addr   = !is_eot && !is_newline && (char_position == PosAddr0) && gap_fire;
  assign rec_fire      = finish_active && in_range;

  always_comb begin
    gap_res            = '0;
    gap_res.kind       = KIND_GAP;
    gap_res.address    = gap_start;
    gap_res.byte_value = FillByte;
    gap_res.gap_length = gap_cmp_addr - gap_start;

    rec_res            = '0;
    rec_res.kind       = KIND_RECORD;
    rec_res.address    = field_address;
    rec_res.rec_type   = field_type;
    rec_res.rec_length = field_length;
    rec_res.checksum   = field_checksum;

    done_res           = '0;
    done_res.kind      = KIND_DONE;

    data_res            = '0;
    data_res.kind       = KIND_DATA;
    data_res.address    = data_address;
    data_res.byte_value = data_byte;
  end

  // Order the results of this beat into at most two slots.
  always_comb begin
    res0      = '0;
    res1      = '0;
    res_count = 2'd0;
    if (is_eot) begin
      if (gap_at_finish) begin
        res0      = gap_res;
        res1      = rec_fire ? rec_res : done_res;
        res_count = 2'd2;
      end else if (rec_fire) begin
        res0      = rec_res;
        res1      = done_res;
        res_count = 2'd2;
      end else begin
        res0      = done_res;
        res_count = 2'd1;
      end
      if (res_count == 2'd2) begin
        res1.last = 1'b1;
      end else begin
        res0.last = 1'b1;
      end
    end else if (is_newline) begin
      if (gap_at_finish && rec_fire) begin
        res0      = gap_res;
        res1      = rec_res;
        res_count = 2'd2;
      end else if (gap_at_finish) begin
        res0      = gap_res;
        res_count = 2'd1;
      end else if (rec_fire) begin
        res0      = rec_res;
        res_count = 2'd1;
      end
    end else if (gap_at_addr) begin
      res0      = gap_res;
      res_count = 2'd1;
    end else if (data_fire) begin
      res0      = data_res;
      res_count = 2'd1;
    end
  end

  // Line bookkeeping and gap tracking.
  always_comb begin
    char_position_next = char_position;
    line_count_next    = line_count;
    gap_pending_next   = gap_pending;
    gap_start_next     = gap_start;
    if (is_eot) begin
      char_position_next = 10'd0;
      line_count_next    = 16'd0;
      gap_pending_next   = 1'b0;
      gap_start_next     = 16'd0;
    end else if (is_newline) begin
      char_position_next = 10'd0;
      if (line_count != 16'hFFFF) begin
        line_count_next = line_count + 16'd1;
      end
      if (char_position < PosTypeHi) begin
        gap_pending_next = 1'b0;
      end
      if (in_range && (field_type == 8'd0)) begin
        gap_pending_next = 1'b1;
        gap_start_next   = field_address + {8'd0, field_length};
      end
    end else begin
      if (char_position < PosMax) begin
        char_position_next = char_position + 10'd1;
      end
      if (char_position == PosAddr0) begin
        gap_pending_next = 1'b0;
      end
    end
  end

  // State registers; a line end clears all field registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_line     <= 16'd0;
      final_line     <= 16'hFFFF;
      char_position  <= 10'd0;
      line_count     <= 16'd0;
      field_length   <= 8'd0;
      field_address  <= 16'd0;
      field_type     <= 8'd0;
      field_checksum <= 8'd0;
      high_nibble    <= 8'd0;
      data_address   <= 16'd0;
      gap_pending    <= 1'b0;
      gap_start      <= 16'd0;
    end else begin
      if (wr_en) begin
        if (wr_index == CFG_FIRST_LINE) begin
          first_line <= wr_data;
        end else begin
          final_line <= wr_data;
        end
      end
      if (accept) begin
        char_position <= char_position_next;
        line_count    <= line_count_next;
        gap_pending   <= gap_pending_next;
        gap_start     <= gap_start_next;
        if (is_eot || is_newline) begin
          field_length   <= 8'd0;
          field_address  <= 16'd0;
          field_type     <= 8'd0;
          field_checksum <= 8'd0;
          high_nibble    <= 8'd0;
          data_address   <= 16'd0;
        end else begin
          field_length   <= field_length_next;
          field_address  <= field_address_next;
          field_type     <= field_type_next;
          field_checksum <= field_checksum_next;
          high_nibble    <= high_nibble_next;
          data_address   <= data_address_next;
        end
      end
    end
  end

endmodule

// File: hw/rtl/hrsp_out_fifo.sv
// Small result queue that takes up to two results per cycle and sends one per beat.
module hrsp_out_fifo #(
  parameter int unsigned DEPTH = hrsp_pkg::OutDepthDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    push_count,
  input  hrsp_pkg::result_t             din0,
  input  hrsp_pkg::result_t             din1,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hrsp_pkg::result_t             dout,
  output logic                          room_for_two,
  output logic [$clog2(DEPTH+1)-1:0]    level
);
  import hrsp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LvlW = $clog2(DEPTH + 1);

  result_t         mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW-1:0] wr_ptr_p1;
  logic [PtrW-1:0] wr_ptr_p2;
  logic [PtrW-1:0] rd_ptr_next;
  logic [PtrW-1:0] wr_ptr_next;
  logic [LvlW-1:0] level_next;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign out_valid    = (level != '0);
  assign dout         = mem[rd_ptr];
  assign pop          = out_valid && out_ready;
  assign room_for_two = (level <= LvlW'(DEPTH - 2));

  // Pointer and fill level arithmetic.
  always_comb begin
    wr_ptr_p1   = ptr_inc(wr_ptr);
    wr_ptr_p2   = ptr_inc(wr_ptr_p1);
    rd_ptr_next = pop ? ptr_inc(rd_ptr) : rd_ptr;
    case (push_count)
      2'd1:    wr_ptr_next = wr_ptr_p1;
      2'd2:    wr_ptr_next = wr_ptr_p2;
      default: wr_ptr_next = wr_ptr;
    endcase
    level_next = level + LvlW'(push_count) - LvlW'(pop);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      level  <= level_next;
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= din0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr_p1] <= din1;
    end
  end

endmodule

// File: hw/rtl/hex_record_stream_parser_top.sv
// Top level of the hex record stream parser.
//
// char_in carries one text character per beat (char_code), or an end marker
// (end_of_text). Each line drops its first character, then decodes length,
// address, type, data and checksum digits. result_out carries data bytes,
// 0xFF gap runs, record summaries and a final stream done item; the last
// result of a stream has last set. wr_en/wr_index/wr_data write first_line
// (index 0) and final_line (index 1), the inclusive window of lines that
// produce results; write them only while the block is idle.
// Throughput is one character per cycle while char_in.ready is high. A
// character updates the field registers in the cycle it is accepted and its
// results, at most two, land in a four-entry result queue, so a result is
// registered before it reaches result_out. The queue drains one result per
// cycle while the receiver is ready, so the two results of a newline leave
// one after the other. char_in.ready drops while the queue lacks room for
// two results: when the receiver stalls, or after two close two-result beats.
// Synchronous rst returns the parser, the queue and both line registers to
// their reset values.
module hex_record_stream_parser_top #(
  parameter int unsigned MAX_DATA_BYTES = hrsp_pkg::MaxDataBytesDefault,
  parameter int unsigned OUT_DEPTH      = hrsp_pkg::OutDepthDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [hrsp_pkg::CfgIndexW-1:0]  wr_index,
  input  logic [hrsp_pkg::CfgWidth-1:0]   wr_data,
  hrsp_stream_if.sink                     char_in,
  hrsp_stream_if.source                   result_out
);
  import hrsp_pkg::*;

  localparam int unsigned LvlW = $clog2(OUT_DEPTH + 1);

  logic            accept;
  logic            pop;
  char_beat_t      beat;
  result_t         res0;
  result_t         res1;
  logic [1:0]      res_count;
  logic [1:0]      push_count;
  logic            room_for_two;
  logic [LvlW-1:0] level;
  result_t         head;

  assign beat       = char_in.payload;
  assign accept     = char_in.valid && char_in.ready;
  assign push_count = accept ? res_count : 2'd0;
  assign pop        = result_out.valid && result_out.ready;

  // Character decode and field state.
  hrsp_parse #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .accept    (accept),
    .beat      (beat),
    .res0      (res0),
    .res1      (res1),
    .res_count (res_count)
  );

  // Result queue between the parser and the receiver.
  hrsp_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .push_count   (push_count),
    .din0         (res0),
    .din1         (res1),
    .out_valid    (result_out.valid),
    .out_ready    (result_out.ready),
    .dout         (head),
    .room_for_two (room_for_two),
    .level        (level)
  );

  assign char_in.ready      = room_for_two;
  assign result_out.payload = head;

  // The queue level follows exactly the pushes and pops of the previous cycle.
  assert property (@(posedge clk) disable iff (rst)
    !rst |=> ({1'b0, level} ==
              {1'b0, $past(level)} + (LvlW+1)'($past(push_count)) - (LvlW+1)'($past(pop))))
    else $error("result queue level lost track of pushes and pops");

  // An end marker always produces results and flags the final one.
  assert property (@(posedge clk) disable iff (rst)
    (accept && beat.end_of_text) |->
      ((res_count == 2'd2 && res1.last) || (res_count == 2'd1 && res0.last)))
    else $error("end of text beat did not close the stream");

  // Ordinary characters never mark the end of the stream.
  assert property (@(posedge clk) disable iff (rst)
    (accept && !beat.end_of_text) |-> (!res0.last && !res1.last))
    else $error("last flag set on a result of an ordinary character");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the hex record stream parser top level.
module tb_top;
  import hrsp_pkg::*;

  localparam int CycleLimit  = 1000000;
  localparam int SettleTicks = 8;
  localparam int LongHold    = 120;
  localparam int MaxPerChar  = 2;
  localparam logic [7:0] RecordMark = 8'h3A;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [CfgIndexW-1:0] wr_index;
  logic [CfgWidth-1:0] wr_data;

  hrsp_stream_if #(.payload_t(char_beat_t)) char_in_if ();
  hrsp_stream_if #(.payload_t(result_t)) result_if ();

  hex_record_stream_parser_top uut (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .char_in    (char_in_if),
    .result_out (result_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Characters waiting to be sent and results the parser still owes.
  char_beat_t chars_to_send[$];
  result_t    results_due[$];
  result_t    step_results[$];

  int chars_queued = 0;
  int chars_accepted = 0;
  int errors = 0;
  int cycle_count = 0;

  logic char_taken = 1'b0;
  logic res_taken = 1'b0;
  int tx_wait = 0;
  int tx_run = 0;
  int rx_wait = 0;
  int rx_run = 0;
  int hold_kick = 0;
  int hold_seen = 0;
  logic [15:0] next_addr = 16'd0;

  // Parser state as predicted by the testbench.
  logic [15:0] win_first, win_final;
  logic [9:0]  col;
  logic [15:0] line_no;
  logic [7:0]  rec_len, rec_kind, rec_chk, nib_hi;
  logic [15:0] rec_addr, byte_addr, gap_from;
  logic        gap_armed;

  function automatic logic [7:0] hex_nibble(input logic [7:0] c);
    if (c >= Char0 && c <= Char9) return c - Char0;
    if (c >= CharLowA && c <= CharLowF) return c - CharLowA + 8'd10;
    if (c >= CharUpA && c <= CharUpF) return c - CharUpA + 8'd10;
    return c;
  endfunction

  // The first digit of a byte lands in the upper nibble, the second is ORed in.
  function automatic logic [7:0] merge_digit(input logic [7:0] cur, input bit lead,
                                             input logic [7:0] v);
    if (lead) return {v[3:0], 4'b0000};
    return cur | v;
  endfunction

  function automatic bit in_window();
    return line_no >= win_first && line_no <= win_final;
  endfunction

  function automatic result_t make_result(input kind_t k, input logic [15:0] addr,
                                          input logic [7:0] val, input logic [15:0] glen,
                                          input logic [7:0] typ, input logic [7:0] len,
                                          input logic [7:0] chk);
    result_t r;
    r.kind = k;
    r.address = addr;
    r.byte_value = val;
    r.gap_length = glen;
    r.rec_type = typ;
    r.rec_length = len;
    r.checksum = chk;
    r.last = 1'b0;
    return r;
  endfunction

  // A single character never yields more than two results; extras are dropped.
  task automatic add_result(input result_t r);
    if (step_results.size() < MaxPerChar) step_results.push_back(r);
  endtask

  task automatic clear_fields();
    col = '0;
    rec_len = '0;
    rec_addr = '0;
    rec_kind = '0;
    rec_chk = '0;
    nib_hi = '0;
    byte_addr = '0;
  endtask

  task automatic reset_parser_model();
    win_first = 16'd0;
    win_final = 16'hFFFF;
    line_no = 16'd0;
    gap_armed = 1'b0;
    gap_from = 16'd0;
    clear_fields();
  endtask

  // A pending fill run closes once the following address is known.
  task automatic check_gap();
    if (gap_armed) begin
      gap_armed = 1'b0;
      if (rec_addr > gap_from) begin
        add_result(make_result(KIND_GAP, gap_from, FillByte, rec_addr - gap_from,
                               8'd0, 8'd0, 8'd0));
      end
    end
  endtask

  task automatic close_line();
    if (col < 10'd7) check_gap();
    if (in_window()) begin
      add_result(make_result(KIND_RECORD, rec_addr, 8'd0, 16'd0, rec_kind, rec_len, rec_chk));
      if (rec_kind == 8'd0) begin
        gap_armed = 1'b1;
        gap_from = rec_addr + {8'd0, rec_len};
      end
    end
  endtask

  // Predict the results of one accepted character beat.
  task automatic parse_char(input char_beat_t beat);
    int p, dend;
    logic [7:0] c, v, hi, lo;
    result_t r;
    c = beat.char_code;
    step_results.delete();
    if (beat.end_of_text) begin
      if (col > 10'd0) close_line();
      add_result(make_result(KIND_DONE, 16'd0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0));
      r = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
      line_no = 16'd0;
      gap_armed = 1'b0;
      gap_from = 16'd0;
      clear_fields();
    end else if (c == CharNewline) begin
      close_line();
      if (line_no != 16'hFFFF) line_no = line_no + 16'd1;
      clear_fields();
    end else begin
      p = int'(col);
      if (col < PosMax) col = col + 10'd1;
      v = hex_nibble(c);
      dend = 9 + 2 * int'(rec_len);
      if (p == 1 || p == 2) begin
        rec_len = merge_digit(rec_len, p == 1, v);
      end else if (p >= 3 && p <= 6) begin
        hi = rec_addr[15:8];
        lo = rec_addr[7:0];
        if (p <= 4) hi = merge_digit(hi, p == 3, v);
        else lo = merge_digit(lo, p == 5, v);
        rec_addr = {hi, lo};
        if (p == 6) check_gap();
      end else if (p == 7 || p == 8) begin
        rec_kind = merge_digit(rec_kind, p == 7, v);
        if (p == 8) byte_addr = rec_addr;
      end else if (p >= 9 && p < dend) begin
        // Data digits are folded to lower case before decoding.
        if (c >= CharUpA && c <= CharUpZ) v = hex_nibble(c + (CharLowA - CharUpA));
        if (((p - 9) % 2) == 0) begin
          nib_hi = v;
        end else begin
          if (in_window() && rec_kind == 8'd0) begin
            add_result(make_result(KIND_DATA, byte_addr, {nib_hi[3:0], 4'b0000} | v,
                                   16'd0, 8'd0, 8'd0, 8'd0));
          end
          byte_addr = byte_addr + 16'd1;
        end
      end else if (p == dend || p == dend + 1) begin
        rec_chk = merge_digit(rec_chk, p == dend, v);
      end
    end
    foreach (step_results[i]) results_due.push_back(step_results[i]);
  endtask

  // Compare one result beat against the oldest prediction.
  task automatic check_result(input result_t got);
    result_t want;
    if (results_due.size() == 0) begin
      $error("unexpected result: kind %0d, address %h", got.kind, got.address);
      errors++;
    end else begin
      want = results_due.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.address !== want.address) begin
        $error("address: expected %h, actual %h", want.address, got.address);
        errors++;
      end
      if (got.byte_value !== want.byte_value) begin
        $error("byte_value: expected %h, actual %h", want.byte_value, got.byte_value);
        errors++;
      end
      if (got.gap_length !== want.gap_length) begin
        $error("gap_length: expected %0d, actual %0d", want.gap_length, got.gap_length);
        errors++;
      end
      if (got.rec_type !== want.rec_type) begin
        $error("rec_type: expected %h, actual %h", want.rec_type, got.rec_type);
        errors++;
      end
      if (got.rec_length !== want.rec_length) begin
        $error("rec_length: expected %0d, actual %0d", want.rec_length, got.rec_length);
        errors++;
      end
      if (got.checksum !== want.checksum) begin
        $error("checksum: expected %h, actual %h", want.checksum, got.checksum);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    end
  endtask

  // Monitor: sample both channels and the register port at the rising edge.
  always @(posedge clk) begin
    cycle_count++;
    if (rst) begin
      reset_parser_model();
      char_taken <= 1'b0;
      res_taken <= 1'b0;
    end else begin
      char_taken <= char_in_if.valid && char_in_if.ready;
      res_taken <= result_if.valid && result_if.ready;
      if (result_if.valid && result_if.ready) check_result(result_if.payload);
      if (char_in_if.valid && char_in_if.ready) begin
        parse_char(char_in_if.payload);
        chars_accepted++;
      end
      if (wr_en) begin
        if (wr_index == CFG_FIRST_LINE) win_first = wr_data;
        else if (wr_index == CFG_FINAL_LINE) win_final = wr_data;
      end
    end
  end

  // Character driver: one beat per queued item, with a random gap after each outside of back-to-back runs.
  always @(negedge clk) begin
    if (rst) begin
      char_in_if.valid <= 1'b0;
      tx_wait = 0;
    end else if (!char_in_if.valid || char_taken) begin
      if (tx_wait > 0) begin
        tx_wait--;
        char_in_if.valid <= 1'b0;
      end else if (chars_to_send.size() > 0) begin
        char_in_if.payload <= chars_to_send.pop_front();
        char_in_if.valid <= 1'b1;
        if (tx_run > 0) begin
          tx_wait = 0;
          tx_run--;
        end else if ($urandom_range(0, 29) == 0) begin
          tx_run = 20;
          tx_wait = 0;
        end else begin
          tx_wait = $urandom_range(0, 3);
        end
      end else begin
        char_in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls per beat, plus a long hold when requested.
  always @(negedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (hold_kick != hold_seen) begin
        hold_seen = hold_kick;
        rx_wait = LongHold;
      end else if (res_taken) begin
        if (rx_run > 0) begin
          rx_run--;
          rx_wait = 0;
        end else if ($urandom_range(0, 29) == 0) begin
          rx_run = 25;
          rx_wait = 0;
        end else begin
          rx_wait = $urandom_range(0, 3);
        end
      end
      if (rx_wait > 0) begin
        rx_wait--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = $urandom_range(0, 255);
    if (c == CharNewline) c = 8'h2E;
    return c;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) return Char0 + n;
    if ($urandom_range(0, 1) == 1) return CharUpA + (n - 4'd10);
    return CharLowA + (n - 4'd10);
  endfunction

  task automatic send_char(input logic [7:0] c);
    char_beat_t beat;
    beat.char_code = c;
    beat.end_of_text = 1'b0;
    chars_to_send.push_back(beat);
    chars_queued++;
  endtask

  task automatic send_end();
    char_beat_t beat;
    beat.char_code = $urandom_range(0, 255);
    beat.end_of_text = 1'b1;
    chars_to_send.push_back(beat);
    chars_queued++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Build one record line, optionally cut short or hit by a stray character.
  task automatic send_record(input int len, input logic [15:0] addr,
                             input logic [7:0] kind_code, input int junk, input bit cut,
                             input bit noisy, input bit with_newline);
    logic [7:0] line_chars[$];
    logic [7:0] fields[$];
    logic [7:0] b;
    int i, keep;
    line_chars.push_back(($urandom_range(0, 9) == 0) ? text_char() : RecordMark);
    fields.push_back(len[7:0]);
    fields.push_back(addr[15:8]);
    fields.push_back(addr[7:0]);
    fields.push_back(kind_code);
    for (i = 0; i < len; i++) fields.push_back($urandom_range(0, 255));
    fields.push_back($urandom_range(0, 255));
    foreach (fields[j]) begin
      if (j >= 4 && $urandom_range(0, 24) == 0) begin
        line_chars.push_back(text_char());
        line_chars.push_back(text_char());
      end else begin
        line_chars.push_back(hex_digit(fields[j][7:4]));
        line_chars.push_back(hex_digit(fields[j][3:0]));
      end
    end
    for (i = 0; i < junk; i++) line_chars.push_back(text_char());
    if (cut) begin
      keep = $urandom_range(0, line_chars.size() - 1);
      while (line_chars.size() > keep) b = line_chars.pop_back();
    end
    if (noisy && line_chars.size() > 0) begin
      line_chars[$urandom_range(0, line_chars.size() - 1)] = $urandom_range(0, 255);
    end
    foreach (line_chars[j]) send_char(line_chars[j]);
    if (with_newline) send_char(CharNewline);
  endtask

  // Mostly well-formed records with random content, some empty or junk lines.
  task automatic send_random_line(input bit with_newline);
    int mode, len, n, i;
    logic [15:0] addr;
    logic [7:0] kind_code;
    mode = $urandom_range(0, 99);
    if (mode < 6) begin
      if (with_newline) send_char(CharNewline);
      else send_char(text_char());
    end else if (mode < 12) begin
      n = $urandom_range(1, 12);
      for (i = 0; i < n; i++) send_char(text_char());
      if (with_newline) send_char(CharNewline);
    end else begin
      n = $urandom_range(0, 99);
      len = (n < 80) ? $urandom_range(0, 6) : $urandom_range(7, 24);
      n = $urandom_range(0, 99);
      if (n < 50) addr = next_addr;
      else if (n < 75) addr = next_addr + $urandom_range(1, 40);
      else if (n < 90) addr = $urandom_range(0, 65535);
      else addr = next_addr - $urandom_range(1, 8);
      n = $urandom_range(0, 99);
      if (n < 70) kind_code = 8'd0;
      else if (n < 90) kind_code = $urandom_range(1, 5);
      else kind_code = $urandom_range(0, 255);
      next_addr = addr + len;
      n = $urandom_range(0, 99);
      send_record(len, addr, kind_code, $urandom_range(0, 3), n < 12, n >= 12 && n < 22,
                  with_newline);
    end
  endtask

  // A stream ends after a newline, inside a partial line, or with a doubled end marker.
  task automatic send_stream(input int lines);
    int i, r;
    next_addr = $urandom_range(0, 65535);
    for (i = 0; i < lines; i++) send_random_line(1'b1);
    r = $urandom_range(0, 9);
    if (r >= 5 && r <= 7) send_random_line(1'b0);
    else if (r >= 8) send_end();
    send_end();
  endtask

  task automatic run_random(input int count);
    int base;
    base = chars_queued;
    while (chars_queued - base < count) send_stream($urandom_range(2, 6));
  endtask

  // Wait until every beat is taken and every result is in, then let the block settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (chars_accepted != chars_queued || results_due.size() != 0);
    repeat (SettleTicks) @(negedge clk);
  endtask

  task automatic set_window(input logic [15:0] lo_line, input logic [15:0] hi_line);
    wr_en <= 1'b1;
    wr_index <= CFG_FIRST_LINE;
    wr_data <= lo_line;
    @(negedge clk);
    wr_index <= CFG_FINAL_LINE;
    wr_data <= hi_line;
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Stop a hung run.
  initial begin
    while (cycle_count < CycleLimit) @(negedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = CFG_FIRST_LINE;
    wr_data = '0;
    char_in_if.valid = 1'b0;
    char_in_if.payload = '0;
    result_if.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed lines at the reset window: folded and non-hex data digits at the
    // top of the address space, an empty line that drops the pending gap, a
    // partial line ended by the end marker, and an end marker on its own.
    @(posedge clk);
    send_text(":01fffe00Gz\n");
    send_text("\n");
    send_text("x00001001");
    send_end();
    send_end();
    wait_drained();

    // Full window: a long record, with a long receiver hold while characters
    // keep coming.
    set_window(16'd0, 16'hFFFF);
    @(posedge clk);
    hold_kick++;
    send_record(24, 16'h1000, 8'd0, 0, 1'b0, 1'b0, 1'b1);
    send_end();
    run_random(60);
    wait_drained();

    // Narrow window, with a pause for the results in the middle.
    set_window(16'd1, 16'd3);
    @(posedge clk);
    run_random(30);
    wait_drained();
    @(posedge clk);
    run_random(30);
    wait_drained();

    // Only the first line of each stream.
    set_window(16'd0, 16'd0);
    @(posedge clk);
    run_random(50);
    wait_drained();

    // Empty window: nothing but stream done markers come out.
    set_window(16'd5, 16'd2);
    @(posedge clk);
    run_random(40);
    wait_drained();

    // Open-ended window with another long hold.
    set_window(16'd2, 16'hFFFF);
    @(posedge clk);
    hold_kick++;
    run_random(90);
    wait_drained();

    if (errors == 0 && results_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
